[src/pdt_pkg.sv]
// Shared types and constants of the phase direction tracker.
package pdt_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned CI_W    = 4;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned STEP_W  = CFG_W + 1;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned SCORE_W = 6;

  localparam int          SCORE_SAT    = 30;
  localparam int          REBASE_SCORE = 6;

  localparam logic [CI_W-1:0]  CONFIRM_RST   = 4'd3;
  localparam logic [CFG_W-1:0] MIN_STEP_RST  = 20'd3660;
  localparam logic [CFG_W-1:0] MAX_STEP_RST  = 20'd658840;
  localparam logic [CFG_W-1:0] WIN_THR_RST   = 20'd27452;
  localparam logic [CI_W-1:0]  NEED_MIN      = 4'd2;

  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_NEG  = 2'sb11;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE       = 3'd0,
    OP_REBASE_KEEP  = 3'd1,
    OP_REBASE_CLEAR = 3'd2,
    OP_SHIFT        = 3'd3,
    OP_CLEAR        = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_CONFIRM    = 2'd0,
    CFG_MIN_STEP   = 2'd1,
    CFG_MAX_STEP   = 2'd2,
    CFG_WIN_THRESH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

endpackage

[src/phase_direction_tracker.sv]
// Phase direction tracker top level: stream ports, command decode, decision logic.
// Takes one command per cycle when the output is not stalled (update, rebase keeping
// or clearing the direction, reference shift, full clear) and returns exactly one
// result per command: the command passes one input register, then the step, window
// and score update runs in one pass into the output register. The window keeps
// running step and vote sums, so the update does not depend on WINDOW_DEPTH. The
// window needs no clearing pass after reset.
module phase_direction_tracker
  import pdt_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // [31:0] angle
  input  logic [OP_W-1:0]   s_axis_tuser,  // [2:0] op
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata   // direction, score, window decision,
                                           // sample_taken, has_reference, zero pad
);

  localparam int unsigned PtrW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW  = STEP_W + PtrW;
  localparam int unsigned VsumW = FillW + 1;
  localparam logic signed [SCORE_W:0]   ScoreMax = (SCORE_W+1)'(SCORE_SAT);
  localparam logic signed [SCORE_W-1:0] ScoreHi  = SCORE_W'(SCORE_SAT);
  localparam logic signed [SCORE_W-1:0] ScoreLo  = -ScoreHi;
  localparam logic signed [SCORE_W-1:0] RebPos   = SCORE_W'(REBASE_SCORE);

  // configuration
  logic [CI_W-1:0]  confirm_q;
  logic [CFG_W-1:0] min_step_q, max_step_q, win_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q  <= CONFIRM_RST;
      min_step_q <= MIN_STEP_RST;
      max_step_q <= MAX_STEP_RST;
      win_thr_q  <= WIN_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CONFIRM:    confirm_q  <= cfg_data_i[CI_W-1:0];
        CFG_MIN_STEP:   min_step_q <= cfg_data_i;
        CFG_MAX_STEP:   max_step_q <= cfg_data_i;
        CFG_WIN_THRESH: win_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                      in_vld_q;
  logic [OP_W-1:0]           op_q;
  logic signed [ANGLE_W-1:0] angle_q;
  logic                      adv;
  logic                      out_vld_q;
  logic [15:0]               out_data_q;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= s_axis_tuser;
      angle_q <= s_axis_tdata;
    end
  end

  // tracker state
  logic                      ref_valid_q, ref_valid_d;
  logic signed [ANGLE_W-1:0] ref_phase_q, ref_phase_d;
  logic signed [DIR_W-1:0]   dir_q, dir_d, wdir;
  logic signed [SCORE_W-1:0] score_q, score_d, score_sat, score_mag;
  logic signed [SCORE_W:0]   score_sum;
  logic                      taken;
  win_ctrl_t                 ctrl;

  // step and filter
  logic signed [ANGLE_W:0]   step;
  logic [ANGLE_W:0]          step_mag;
  logic                      keep, sdir_pos;
  logic [CI_W-1:0]           need;

  assign step     = (ANGLE_W+1)'(angle_q) - (ANGLE_W+1)'(ref_phase_q);
  assign step_mag = step[ANGLE_W] ? $unsigned(-step) : $unsigned(step);
  assign keep     = (step_mag > (ANGLE_W+1)'(min_step_q))
                 && (step_mag < (ANGLE_W+1)'(max_step_q));
  assign sdir_pos = !step[ANGLE_W] && (step != '0);
  assign need     = (confirm_q < NEED_MIN) ? NEED_MIN : confirm_q;

  // window
  logic signed [SumW-1:0]  dsum;
  logic signed [VsumW-1:0] vsum;
  logic [FillW-1:0]        fill;
  logic [SumW-1:0]         dmag;
  logic [VsumW-1:0]        vmag;
  logic                    dpos, win_ok, score_ok;

  pdt_window #(
    .Depth (WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .step_i (step[STEP_W-1:0]),
    .vote_i (sdir_pos),
    .dsum_o (dsum),
    .vsum_o (vsum),
    .fill_o (fill)
  );

  assign dmag   = dsum[SumW-1] ? $unsigned(-dsum) : $unsigned(dsum);
  assign vmag   = vsum[VsumW-1] ? $unsigned(-vsum) : $unsigned(vsum);
  assign dpos   = !dsum[SumW-1] && (dsum != '0);
  assign win_ok = (32'(fill) >= 32'(need)) && (32'(dmag) >= 32'(win_thr_q))
               && (32'(vmag) >= 32'(need)) && (dpos == !vsum[VsumW-1]);

  // saturating score
  assign score_sum = (SCORE_W+1)'(score_q) + (sdir_pos ? 7'sd1 : -7'sd1);
  always_comb begin
    if (score_sum > ScoreMax) begin
      score_sat = ScoreHi;
    end else if (score_sum < -ScoreMax) begin
      score_sat = ScoreLo;
    end else begin
      score_sat = score_sum[SCORE_W-1:0];
    end
  end
  assign score_mag = score_sat[SCORE_W-1] ? -score_sat : score_sat;
  assign score_ok  = ($unsigned(score_mag) >= SCORE_W'(need));

  always_comb begin
    ref_valid_d = ref_valid_q;
    ref_phase_d = ref_phase_q;
    dir_d       = dir_q;
    score_d     = score_q;
    wdir        = DIR_NONE;
    taken       = 1'b0;
    ctrl        = '0;
    unique case (op_q)
      OP_UPDATE, OP_REBASE_KEEP: begin
        if (op_q == OP_REBASE_KEEP || !ref_valid_q) begin
          ref_valid_d = 1'b1;
          ref_phase_d = angle_q;
          if (dir_q != DIR_NONE) begin
            score_d = (dir_q == DIR_POS) ? RebPos : -RebPos;
          end
        end else begin
          ref_phase_d = angle_q;
          if (keep) begin
            taken     = 1'b1;
            ctrl.push = adv;
            score_d   = score_sat;
            if (win_ok) begin
              wdir = dpos ? DIR_POS : DIR_NEG;
              if (dir_q == DIR_NONE && score_ok &&
                  (dpos == !score_sat[SCORE_W-1])) begin
                dir_d = wdir;
              end
            end
          end
        end
      end
      OP_REBASE_CLEAR: begin
        ref_valid_d = 1'b1;
        ref_phase_d = angle_q;
        dir_d       = DIR_NONE;
        score_d     = '0;
        ctrl.clear  = adv;
      end
      OP_SHIFT: begin
        if (ref_valid_q) begin
          ref_phase_d = ref_phase_q + angle_q;
        end
      end
      OP_CLEAR: begin
        ref_valid_d = 1'b0;
        ref_phase_d = '0;
        dir_d       = DIR_NONE;
        score_d     = '0;
        ctrl.clear  = adv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_valid_q <= 1'b0;
      ref_phase_q <= '0;
      dir_q       <= DIR_NONE;
      score_q     <= '0;
    end else if (adv) begin
      ref_valid_q <= ref_valid_d;
      ref_phase_q <= ref_phase_d;
      dir_q       <= dir_d;
      score_q     <= score_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {4'b0, ref_valid_d, taken, wdir, score_d, dir_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_dir_needs_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ref_valid_q |-> dir_q == DIR_NONE)
    else $error("direction latched without reference");

  a_score_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_q <= ScoreHi && score_q >= ScoreLo)
    else $error("score outside limit");

  a_wdir_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !taken |-> wdir == DIR_NONE)
    else $error("window direction without kept step");

endmodule

[src/pdt_window.sv]
// Step and vote window with running sums and fill count.
module pdt_window
  import pdt_pkg::*;
#(
  parameter int unsigned Depth = 8,
  localparam int unsigned PtrW  = $clog2(Depth),
  localparam int unsigned FillW = $clog2(Depth + 1),
  localparam int unsigned SumW  = STEP_W + PtrW,
  localparam int unsigned VsumW = FillW + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  win_ctrl_t               ctrl_i,
  input  logic signed [STEP_W-1:0] step_i,
  input  logic                    vote_i,
  output logic signed [SumW-1:0]  dsum_o,
  output logic signed [VsumW-1:0] vsum_o,
  output logic [FillW-1:0]        fill_o
);

  localparam logic signed [VsumW-1:0] VOne = VsumW'(1);

  logic signed [STEP_W-1:0] step_q [Depth];
  logic                     vote_q [Depth];
  logic [PtrW-1:0]          wpos_q, wpos_d;
  logic [FillW-1:0]         fill_q, fill_d;
  logic signed [SumW-1:0]   dsum_q;
  logic signed [VsumW-1:0]  vsum_q, vsum_d, v_new, v_old, vsum_mag;
  logic signed [SumW:0]     dsum_w;
  logic                     full;

  assign full   = (fill_q == FillW'(Depth));
  assign dsum_w = (SumW+1)'(dsum_q) + (SumW+1)'(step_i)
                - (full ? (SumW+1)'(step_q[wpos_q]) : '0);
  assign v_new  = vote_i ? VOne : -VOne;
  assign v_old  = full ? (vote_q[wpos_q] ? VOne : -VOne) : '0;
  assign vsum_d = vsum_q + v_new - v_old;
  assign wpos_d = (wpos_q == PtrW'(Depth - 1)) ? '0 : wpos_q + PtrW'(1);
  assign fill_d = full ? fill_q : fill_q + FillW'(1);

  assign dsum_o = dsum_w[SumW-1:0];
  assign vsum_o = vsum_d;
  assign fill_o = fill_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      fill_q <= '0;
      dsum_q <= '0;
      vsum_q <= '0;
    end else if (ctrl_i.clear) begin
      wpos_q <= '0;
      fill_q <= '0;
      dsum_q <= '0;
      vsum_q <= '0;
    end else if (ctrl_i.push) begin
      wpos_q <= wpos_d;
      fill_q <= fill_d;
      dsum_q <= dsum_w[SumW-1:0];
      vsum_q <= vsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      step_q[wpos_q] <= step_i;
      vote_q[wpos_q] <= vote_i;
    end
  end

  assign vsum_mag = vsum_q[VsumW-1] ? -vsum_q : vsum_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("window fill above depth");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= PtrW'(Depth - 1))
    else $error("write position out of range");

  a_vote_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $unsigned(vsum_mag) <= VsumW'(fill_q))
    else $error("vote sum exceeds window fill");

endmodule

[verif/tb_phase_direction_tracker.sv]
// Self-checking testbench for phase_direction_tracker with a built-in direction predictor.
`timescale 1ns / 100ps

module tb_phase_direction_tracker
  import pdt_pkg::*;
();

  localparam int WIN_DEPTH   = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 120;

  // op codes with no function
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct {
    int dir;
    int score;
    int wdir;
    int taken;
    int has_ref;
  } verdict_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [31:0]     angle;
  } phase_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_addr_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // [31:0] angle
  logic [OP_W-1:0]   s_axis_tuser = '0;   // [2:0] op

  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [1:0] direction, [7:2] score,
                                          // [9:8] window decision, [10] sample_taken,
                                          // [11] has_reference, [15:12] zero

  phase_direction_tracker #(.WINDOW_DEPTH(WIN_DEPTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of configuration and state
  logic [CI_W-1:0]  cfg_confirm = CONFIRM_RST;
  logic [CFG_W-1:0] cfg_min     = MIN_STEP_RST;
  logic [CFG_W-1:0] cfg_max     = MAX_STEP_RST;
  logic [CFG_W-1:0] cfg_thr     = WIN_THR_RST;

  logic        ref_valid = 1'b0;
  logic [31:0] ref_phase = '0;
  int          dir_latched = 0;
  int          vote_score = 0;
  longint      step_hist[$];
  bit          vote_hist[$];

  phase_cmd_t  phase_cmds[$];
  verdict_t    pending_verdicts[$];

  int errors = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 69;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  logic in_fire = 1'b0;

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  function automatic void take_reference(logic [31:0] ang, bit keep);
    ref_valid = 1'b1;
    ref_phase = ang;
    if (!keep) begin
      step_hist.delete();
      vote_hist.delete();
      dir_latched = 0;
      vote_score = 0;
    end else if (dir_latched != 0) begin
      vote_score = dir_latched * REBASE_SCORE;
    end
  endfunction

  function automatic verdict_t track_phase(logic [OP_W-1:0] op, logic [31:0] ang);
    verdict_t v;
    longint step, mag, need, dsum, vsum;
    int wdir, sd, dd, vd;
    int taken;
    wdir = 0;
    taken = 0;
    case (op)
      OP_UPDATE: begin
        if (!ref_valid) begin
          take_reference(ang, 1'b1);
        end else begin
          step = longint'($signed(ang)) - longint'($signed(ref_phase));
          mag = (step < 0) ? -step : step;
          ref_phase = ang;
          if (mag > longint'(cfg_min) && mag < longint'(cfg_max)) begin
            taken = 1;
            sd = (step > 0) ? 1 : -1;
            need = (cfg_confirm < NEED_MIN) ? 2 : longint'(cfg_confirm);
            step_hist.insert(step_hist.size(), step);
            vote_hist.insert(vote_hist.size(), sd > 0);
            if (step_hist.size() > WIN_DEPTH) begin
              step_hist.delete(0);
              vote_hist.delete(0);
            end
            vote_score += sd;
            if (vote_score > SCORE_SAT) vote_score = SCORE_SAT;
            if (vote_score < -SCORE_SAT) vote_score = -SCORE_SAT;
            dsum = 0;
            vsum = 0;
            foreach (step_hist[i]) begin
              dsum += step_hist[i];
              vsum += vote_hist[i] ? 1 : -1;
            end
            if (step_hist.size() >= need && ((dsum < 0) ? -dsum : dsum) >= longint'(cfg_thr)
                && ((vsum < 0) ? -vsum : vsum) >= need) begin
              // zero step sum counts as negative
              dd = (dsum > 0) ? 1 : -1;
              vd = (vsum > 0) ? 1 : ((vsum < 0) ? -1 : 0);
              if (dd == vd) wdir = dd;
            end
            if (wdir != 0 && dir_latched == 0 &&
                ((wdir > 0 && vote_score >= need) || (wdir < 0 && -vote_score >= need)))
              dir_latched = wdir;
          end
        end
      end
      OP_REBASE_KEEP:  take_reference(ang, 1'b1);
      OP_REBASE_CLEAR: take_reference(ang, 1'b0);
      OP_SHIFT: if (ref_valid) ref_phase = ref_phase + ang;
      OP_CLEAR: begin
        ref_valid = 1'b0;
        ref_phase = '0;
        dir_latched = 0;
        vote_score = 0;
        step_hist.delete();
        vote_hist.delete();
      end
      default: ;
    endcase
    v.dir = dir_latched;
    v.score = vote_score;
    v.wdir = wdir;
    v.taken = taken;
    v.has_ref = ref_valid;
    return v;
  endfunction

  // result check, then prediction of the accepted command
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = pending_verdicts[0];
          pending_verdicts.delete(0);
          if ($isunknown(m_axis_tdata))
            report_mismatch($sformatf("result %0d has unknown bits", results_seen));
          check_field("direction", $signed(m_axis_tdata[1:0]), want.dir);
          check_field("score", $signed(m_axis_tdata[7:2]), want.score);
          check_field("window decision", $signed(m_axis_tdata[9:8]), want.wdir);
          check_field("sample_taken", m_axis_tdata[10], want.taken);
          check_field("has_reference", m_axis_tdata[11], want.has_ref);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_verdicts.insert(pending_verdicts.size(),
                                track_phase(s_axis_tuser, s_axis_tdata));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // command driver
  always @(negedge clk_i) begin
    phase_cmd_t c;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (phase_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        c = phase_cmds[0];
        phase_cmds.delete(0);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= c.angle;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with optional long hold-off
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_cnt = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_cmd(logic [OP_W-1:0] op, logic [31:0] ang);
    phase_cmd_t c;
    c.op = op;
    c.angle = ang;
    phase_cmds.insert(phase_cmds.size(), c);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_CONFIRM:  cfg_confirm = val[CI_W-1:0];
      CFG_MIN_STEP: cfg_min = val;
      CFG_MAX_STEP: cfg_max = val;
      default:      cfg_thr = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [CI_W-1:0] ci, logic [CFG_W-1:0] mn,
                            logic [CFG_W-1:0] mx, logic [CFG_W-1:0] thr);
    write_reg(CFG_CONFIRM, CFG_W'(ci));
    write_reg(CFG_MIN_STEP, mn);
    write_reg(CFG_MAX_STEP, mx);
    write_reg(CFG_WIN_THRESH, thr);
  endtask

  task automatic wait_drained();
    while (phase_cmds.size() != 0 || s_axis_tvalid || pending_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_step();
    logic [31:0] lo, hi;
    lo = 32'(cfg_min) + 1;
    hi = 32'(cfg_max) - 1;
    case ($urandom_range(11))
      0: return 32'(cfg_min);
      1: return 32'(cfg_max);
      2: return $urandom_range(32'(cfg_min));
      3: return $urandom_range(32'hFFFFF);
      4: return $urandom_range(32'h7FFFFFFF);
      default: begin
        if (cfg_max > cfg_min + 1) return $urandom_range(hi, lo);
        return $urandom_range(32'hFFFFF);
      end
    endcase
  endfunction

  // mostly coherent rotation runs with random content, some noise
  task automatic queue_random(int n);
    int made, len, sdir;
    logic [31:0] ph, mag;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 75) begin
        sdir = $urandom_range(1) ? 1 : -1;
        len = $urandom_range(14, 3);
        ph = $urandom();
        case ($urandom_range(2))
          0: push_cmd(OP_REBASE_CLEAR, ph);
          1: push_cmd(OP_REBASE_KEEP, ph);
          default: push_cmd(OP_UPDATE, ph);
        endcase
        made++;
        repeat (len) begin
          mag = pick_step();
          if (($urandom_range(9) == 0) ^ (sdir < 0)) ph = ph - mag;
          else ph = ph + mag;
          if ($urandom_range(24) == 0) begin
            push_cmd(OP_SHIFT, $urandom_range(1) ? $urandom() : $urandom_range(32'h3FFFF));
            made++;
          end
          push_cmd(OP_UPDATE, ph);
          made++;
        end
      end else begin
        push_cmd(OP_W'($urandom_range(7)), $urandom());
        made++;
      end
    end
  endtask

  task automatic queue_directed();
    logic [31:0] a;
    push_cmd(OP_CLEAR, 32'h0);
    push_cmd(OP_SHIFT, 32'h12345678);          // no reference yet: ignored
    push_cmd(OP_UPDATE, 32'h80000000);         // first update takes the reference
    push_cmd(OP_UPDATE, 32'h7FFFFFFF);         // huge step dropped
    push_cmd(OP_REBASE_CLEAR, 32'h0);
    a = 32'(MIN_STEP_RST);
    push_cmd(OP_UPDATE, a);                    // exactly min step
    a = a + 32'(MAX_STEP_RST);
    push_cmd(OP_UPDATE, a);                    // exactly max step
    push_cmd(OP_UPDATE, a);                    // zero step
    repeat (4) begin
      a = a + 32'd20000;
      push_cmd(OP_UPDATE, a);
    end
    push_cmd(OP_REBASE_KEEP, a);               // latched: score forced
    push_cmd(OP_SPARE_A, 32'hFFFFFFFF);
    push_cmd(OP_SPARE_B, 32'h0);
    push_cmd(OP_SPARE_C, 32'h55555555);
    push_cmd(OP_SHIFT, 32'hFFFFFFFF);
    repeat (5) begin
      a = a - 32'd30000;
      push_cmd(OP_UPDATE, a);
    end
    push_cmd(OP_REBASE_CLEAR, 32'h7FFFFFFF);
    push_cmd(OP_UPDATE, 32'h7FFFFFFF - 32'd20000);
    push_cmd(OP_CLEAR, 32'hFFFFFFFF);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration, sender lightly idle, receiver mostly stalled
    queue_directed();
    queue_random(300);
    wait_drained();

    // loosest limits, long receiver hold-off while the sender keeps offering
    set_config(4'd0, 20'd0, 20'hFFFFF, 20'd0);
    queue_random(300);
    hold_asks++;
    wait_drained();

    send_idle_pct = 69;
    recv_idle_pct = 12;
    set_config(4'd8, 20'd100, 20'd200000, 20'd500000);
    queue_random(300);
    wait_drained();

    // every step dropped, window can never decide
    set_config(4'd15, 20'hFFFFF, 20'd0, 20'hFFFFF);
    queue_random(100);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(4'd2, 20'd1000, 20'h80000, 20'hFFFFF);
    queue_random(250);
    wait_drained();

    set_config(4'd5, MIN_STEP_RST, MAX_STEP_RST, WIN_THR_RST);
    queue_random(250);
    wait_drained();

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
